// ===== rtl/stis_pkg.sv =====
// Shared types and constants for the sorted table (insert, remove, search).
package stis_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int FUNC_W    = 2;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int COUNT_W   = 5;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_SEARCH = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} status_t;

	// broadcast command to every cell of the row
	typedef struct packed {
		logic ins;   // insert, table not full
		logic rem;   // remove, value known to be held
	} cmd_t;

endpackage

// ===== rtl/stis_if.sv =====
// Valid/ready channel interfaces for request and response words.
interface stis_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [stis_pkg::FUNC_W-1:0]          func;
	logic signed [stis_pkg::VALUE_W-1:0]  value;

	modport source (output valid, func, value, input ready);
	modport sink   (input valid, func, value, output ready);
endinterface

interface stis_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 found;
	logic [stis_pkg::STATUS_W-1:0]        status;
	logic [stis_pkg::COUNT_W-1:0]         count;

	modport source (output valid, found, status, count, input ready);
	modport sink   (input valid, found, status, count, output ready);
endinterface

// ===== rtl/stis_cell.sv =====
// One slot of the sorted row: holds an entry, compares it, shifts with its neighbours.
module stis_cell (
	input  logic                                clk,
	input  stis_pkg::cmd_t                      cmd,
	input  logic signed [stis_pkg::VALUE_W-1:0] value,
	input  logic                                valid,
	input  logic                                prev_ge,
	input  logic signed [stis_pkg::VALUE_W-1:0] prev_entry,
	input  logic signed [stis_pkg::VALUE_W-1:0] next_entry,
	output logic signed [stis_pkg::VALUE_W-1:0] entry,
	output logic                                ge,
	output logic                                eq
);

	logic signed [stis_pkg::VALUE_W-1:0] entry_q;
	logic signed [stis_pkg::VALUE_W-1:0] entry_d;

	// an empty slot counts as "not smaller", so an insert lands on the first free one
	assign ge    = !valid || (entry_q >= value);
	assign eq    = valid && (entry_q == value);
	assign entry = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (cmd.ins) begin
			if (prev_ge)
				entry_d = prev_entry;
			else if (ge)
				entry_d = value;
		end else if (cmd.rem && ge) begin
			// first slot not below the value is the first match
			entry_d = next_entry;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule

// ===== rtl/sorted_table_insert_remove_search.sv =====
// Sorted table of signed 32-bit values, ascending, duplicates allowed, up to DEPTH entries.
// Each request word (insert, remove or search) is handled in the cycle it is accepted: the
// value is broadcast along a row of DEPTH cells, every cell compares against it at once and
// the row shifts by one slot to open or close a gap. The response word is registered and
// appears in the cycle after acceptance, so one request is taken per cycle; req.ready
// drops only while a response word is held and rsp.ready is low. Insert on a full table
// is dropped with status full, remove and search misses give status not found, function
// code 3 does nothing. The count field is the entry count after the operation, modulo 32.
module sorted_table_insert_remove_search #(
	parameter int DEPTH = stis_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	stis_req_if.sink    req,
	stis_rsp_if.source  rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]                      cnt_q;
	logic [CNT_W-1:0]                      cnt_d;
	logic                                  accept;
	logic                                  full;
	logic                                  hit;
	stis_pkg::cmd_t                        cmd;
	stis_pkg::func_t                       func;
	logic                                  found_d;
	stis_pkg::status_t                     status_d;
	logic [CNT_W+stis_pkg::COUNT_W-1:0]    cnt_ext;

	logic                                  rsp_valid_q;
	logic                                  found_q;
	stis_pkg::status_t                     status_q;
	logic [stis_pkg::COUNT_W-1:0]          count_q;

	logic signed [stis_pkg::VALUE_W-1:0]   entry [DEPTH];
	logic [DEPTH-1:0]                      valid;
	logic [DEPTH-1:0]                      ge;
	logic [DEPTH-1:0]                      eq;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign func      = stis_pkg::func_t'(req.func);
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign hit       = |eq;

	// cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                                prev_ge_w;
		logic signed [stis_pkg::VALUE_W-1:0] prev_entry_w;
		logic signed [stis_pkg::VALUE_W-1:0] next_entry_w;

		assign valid[i] = (CNT_W'(i) < cnt_q);

		if (i == 0) begin : g_first
			assign prev_ge_w    = 1'b0;
			assign prev_entry_w = req.value;
		end else begin : g_mid
			assign prev_ge_w    = ge[i-1];
			assign prev_entry_w = entry[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign next_entry_w = entry[i];
		end else begin : g_inner
			assign next_entry_w = entry[i+1];
		end

		stis_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.value      (req.value),
			.valid      (valid[i]),
			.prev_ge    (prev_ge_w),
			.prev_entry (prev_entry_w),
			.next_entry (next_entry_w),
			.entry      (entry[i]),
			.ge         (ge[i]),
			.eq         (eq[i])
		);
	end

	always_comb begin
		cmd      = '0;
		found_d  = 1'b0;
		status_d = stis_pkg::ST_OK;
		cnt_d    = cnt_q;
		case (func)
			stis_pkg::FUNC_INSERT: begin
				if (full) begin
					status_d = stis_pkg::ST_FULL;
				end else begin
					cmd.ins = accept;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			stis_pkg::FUNC_REMOVE: begin
				if (hit) begin
					cmd.rem = accept;
					found_d = 1'b1;
					cnt_d   = cnt_q - CNT_W'(1);
				end else begin
					status_d = stis_pkg::ST_MISS;
				end
			end
			stis_pkg::FUNC_SEARCH: begin
				if (hit)
					found_d = 1'b1;
				else
					status_d = stis_pkg::ST_MISS;
			end
			default: begin
			end
		endcase
	end

	assign cnt_ext = {{stis_pkg::COUNT_W{1'b0}}, cnt_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept)
				cnt_q <= cnt_d;
			if (req.ready)
				rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			found_q  <= found_d;
			status_q <= status_d;
			count_q  <= cnt_ext[stis_pkg::COUNT_W-1:0];
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.found  = found_q;
	assign rsp.status = status_q;
	assign rsp.count  = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("entry count beyond table depth");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == stis_pkg::FUNC_INSERT && full
		|=> rsp.valid && rsp.status == stis_pkg::ST_FULL && $stable(cnt_q))
		else $error("insert on full table not dropped");

	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && func == stis_pkg::FUNC_REMOVE && hit
		|=> cnt_q == $past(cnt_q) - CNT_W'(1) && rsp.found)
		else $error("remove did not shrink table");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while response word stalled");

endmodule
